>>> rtl/gev_pkg.sv
// shared constants, phase codes and inter-module types of the gesture event detector
package gev_pkg;

  localparam int REST_TICKS = 30;
  localparam int SIGN_TICKS = 60;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 16;
  localparam int EV_W       = 12;
  localparam int NUM_CH     = 6;
  localparam int NUM_FINGER = 3;
  localparam int CH_W       = $clog2(NUM_CH);
  localparam int SH_W       = $clog2(EV_W);
  localparam int PHASE_W    = 3;

  localparam int IN_DATA_W  = NUM_CH * SAMPLE_W;
  localparam int OUT_DATA_W = ((EV_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 1 + PHASE_W;

  // running sum of REST_TICKS-1 samples needs log2(REST_TICKS) growth bits
  localparam int REST_LOG  = $clog2(REST_TICKS);
  localparam int SUM_W     = SAMPLE_W + REST_LOG;
  localparam int ENTRY_W   = SUM_W + 1;
  localparam int CMP_W     = SUM_W + 2;

  // divide by REST_TICKS as multiply by rounded-up reciprocal, exact for |x| < 2^SUM_W
  localparam int DIV_SHIFT = SUM_W + REST_LOG;
  localparam int RECIP_W   = SUM_W + 2;
  localparam int PROD_W    = DIV_SHIFT + SUM_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(REST_TICKS) - 64'd1) / 64'(REST_TICKS));

  localparam int CYCLE_LEN = REST_TICKS + SIGN_TICKS + 2;
  localparam int TICK_W    = $clog2(CYCLE_LEN);
  localparam logic [TICK_W-1:0] TICK_REST   = TICK_W'(REST_TICKS);
  localparam logic [TICK_W-1:0] TICK_REPORT = TICK_W'(REST_TICKS + SIGN_TICKS);
  localparam logic [TICK_W-1:0] TICK_LAST   = TICK_W'(CYCLE_LEN - 1);

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SUM    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BASE   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DETECT = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REPORT = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CLEAR  = 3'd5;

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_STRAIN_THR = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_BAND = 1'd1;
  localparam logic [CFG_W-1:0] STRAIN_THR_RST = 16'd500;
  localparam logic [CFG_W-1:0] ACCEL_BAND_RST = 16'd500;

  // one channel step issued to the state pipeline
  typedef struct packed {
    logic                vld;
    logic [CH_W-1:0]     ch;
    logic [PHASE_W-1:0]  kind;
    logic [SAMPLE_W-1:0] sample;
  } gev_req_t;

  // per-channel result coming back from the state pipeline
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               busy;
    logic [PHASE_W-1:0] kind;
    logic [EV_W-1:0]    bits;
  } gev_done_t;

endpackage

>>> rtl/gev_ram.sv
// generic single-write single-read ram with registered read data
module gev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/gev_chan_pipe.sv
// read-modify-write pipeline over the per-channel sum / baseline / armed memory
module gev_chan_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gev_pkg::gev_req_t           req,
  input  logic [gev_pkg::CFG_W-1:0]   strain_thr,
  input  logic [gev_pkg::CFG_W-1:0]   accel_band,
  output gev_pkg::gev_done_t          done
);

  logic [gev_pkg::ENTRY_W-1:0] rd_data;
  logic [gev_pkg::ENTRY_W-1:0] wr_data;
  logic [gev_pkg::NUM_CH-1:0]  ent_valid_r;

  // read stage
  logic                          s1_vld_r;
  logic [gev_pkg::CH_W-1:0]      s1_ch_r;
  logic [gev_pkg::PHASE_W-1:0]   s1_kind_r;
  logic [gev_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic [gev_pkg::ENTRY_W-1:0]   s1_entry;
  logic [gev_pkg::SUM_W-1:0]     s1_sum;
  logic                          s1_neg;
  logic [gev_pkg::SUM_W-1:0]     s1_mag;
  logic [gev_pkg::PROD_W-1:0]    s1_prod;

  // update stage
  logic                          s2_vld_r;
  logic [gev_pkg::CH_W-1:0]      s2_ch_r;
  logic [gev_pkg::PHASE_W-1:0]   s2_kind_r;
  logic [gev_pkg::SAMPLE_W-1:0]  s2_sample_r;
  logic [gev_pkg::SUM_W-1:0]     s2_sum_r;
  logic                          s2_armed_r;
  logic                          s2_neg_r;
  logic [gev_pkg::PROD_W-1:0]    s2_prod_r;

  logic [gev_pkg::SUM_W-1:0]     quot;
  logic [gev_pkg::SUM_W-1:0]     base_div;
  logic [gev_pkg::SUM_W-1:0]     samp_ext;
  logic [gev_pkg::CMP_W-1:0]     samp_c;
  logic [gev_pkg::CMP_W-1:0]     base_c;
  logic [gev_pkg::CMP_W-1:0]     bent_lim;
  logic [gev_pkg::CMP_W-1:0]     band_hi;
  logic [gev_pkg::CMP_W-1:0]     band_lo;
  logic                          is_finger;
  logic [gev_pkg::SUM_W-1:0]     new_sum;
  logic                          new_armed;
  logic                          ev_hi;
  logic                          ev_lo;
  logic [gev_pkg::SH_W-1:0]      ev_sh;
  logic [gev_pkg::EV_W-1:0]      ev_bits;

  gev_ram #(
    .WIDTH (gev_pkg::ENTRY_W),
    .DEPTH (gev_pkg::NUM_CH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s2_vld_r),
    .waddr (s2_ch_r),
    .wdata (wr_data),
    .re    (req.vld),
    .raddr (req.ch),
    .rdata (rd_data)
  );

  // entries never written since reset read as zero sum, armed
  always_comb begin
    s1_entry = ent_valid_r[s1_ch_r] ? rd_data : {1'b1, {gev_pkg::SUM_W{1'b0}}};
    s1_sum   = s1_entry[gev_pkg::SUM_W-1:0];
    s1_neg   = s1_sum[gev_pkg::SUM_W-1];
    s1_mag   = s1_neg ? (gev_pkg::SUM_W'(0) - s1_sum) : s1_sum;
    s1_prod  = gev_pkg::PROD_W'(s1_mag) * gev_pkg::PROD_W'(gev_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      ent_valid_r <= '0;
    end else begin
      s1_vld_r <= req.vld;
      s2_vld_r <= s1_vld_r;
      if (s2_vld_r) begin
        ent_valid_r[s2_ch_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ch_r     <= req.ch;
    s1_kind_r   <= req.kind;
    s1_sample_r <= req.sample;
    s2_ch_r     <= s1_ch_r;
    s2_kind_r   <= s1_kind_r;
    s2_sample_r <= s1_sample_r;
    s2_sum_r    <= s1_sum;
    s2_armed_r  <= s1_entry[gev_pkg::SUM_W];
    s2_neg_r    <= s1_neg;
    s2_prod_r   <= s1_prod;
  end

  always_comb begin
    quot     = s2_prod_r[gev_pkg::DIV_SHIFT +: gev_pkg::SUM_W];
    base_div = s2_neg_r ? (gev_pkg::SUM_W'(0) - quot) : quot;
    samp_ext = {{(gev_pkg::SUM_W - gev_pkg::SAMPLE_W){s2_sample_r[gev_pkg::SAMPLE_W-1]}},
                s2_sample_r};
    samp_c   = {{2{samp_ext[gev_pkg::SUM_W-1]}}, samp_ext};
    base_c   = {{2{s2_sum_r[gev_pkg::SUM_W-1]}}, s2_sum_r};
    bent_lim = base_c + {{(gev_pkg::CMP_W - gev_pkg::CFG_W){1'b0}}, strain_thr};
    band_hi  = base_c + {{(gev_pkg::CMP_W - gev_pkg::CFG_W){1'b0}}, accel_band};
    band_lo  = base_c - {{(gev_pkg::CMP_W - gev_pkg::CFG_W){1'b0}}, accel_band};
    is_finger = (s2_ch_r < gev_pkg::CH_W'(gev_pkg::NUM_FINGER));

    new_sum   = s2_sum_r;
    new_armed = s2_armed_r;
    ev_hi     = 1'b0;
    ev_lo     = 1'b0;
    case (s2_kind_r)
      gev_pkg::PH_SUM: begin
        new_sum = s2_sum_r + samp_ext;
      end
      gev_pkg::PH_BASE: begin
        new_sum = base_div;
      end
      gev_pkg::PH_DETECT: begin
        if (is_finger) begin
          // armed means straight; only a change of state raises a bit
          if ($signed(samp_c) <= $signed(bent_lim)) begin
            new_armed = 1'b1;
            ev_hi     = !s2_armed_r;
          end else begin
            new_armed = 1'b0;
            ev_lo     = s2_armed_r;
          end
        end else begin
          if ($signed(samp_c) <= $signed(band_hi) && $signed(samp_c) >= $signed(band_lo)) begin
            new_armed = 1'b1;
          end else begin
            new_armed = 1'b0;
            ev_hi     = s2_armed_r && ($signed(samp_c) < $signed(base_c));
            ev_lo     = s2_armed_r && ($signed(samp_c) > $signed(base_c));
          end
        end
      end
      gev_pkg::PH_CLEAR: begin
        new_sum   = '0;
        new_armed = 1'b1;
      end
      default: begin
        new_sum   = s2_sum_r;
        new_armed = s2_armed_r;
      end
    endcase

    // channel c owns bits 11-2c (straight / negative) and 10-2c (bent / positive)
    ev_sh   = gev_pkg::SH_W'(gev_pkg::EV_W - 2) - gev_pkg::SH_W'({s2_ch_r, 1'b0});
    ev_bits = {{(gev_pkg::EV_W - 2){1'b0}}, ev_hi, ev_lo} << ev_sh;
    wr_data = {new_armed, new_sum};
  end

  assign done.vld  = s2_vld_r;
  assign done.last = (s2_ch_r == gev_pkg::LAST_CH);
  assign done.busy = s1_vld_r || s2_vld_r;
  assign done.kind = s2_kind_r;
  assign done.bits = ev_bits;

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && req.vld |-> s2_ch_r != req.ch)
    else $error("read and write-back hit the same state entry");

  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && (s2_ch_r != gev_pkg::LAST_CH) |-> s1_vld_r && (s1_ch_r == s2_ch_r + 1'b1))
    else $error("channel steps of one transaction left order");

endmodule

>>> rtl/baseline_gesture_event_detector.sv
// top level: tick sequencer, configuration registers and output staging
//
// Usage:
//   in_*  : one transaction per sensor tick, six signed 16-bit samples in in_tdata.
//   out_* : exactly one transaction per input tick, in order; out_tdata holds the
//           12 event bits, out_tuser the summary flag and the phase code.
//   cfg_* : register writes, always ready; index 0 strain threshold, 1 accel band.
//           Write only while no tick is in flight.
// Timing: a tick walks the six channels through the state memory, one channel
// per cycle with a three-stage read-modify-write, and its result is registered
// on out_*. A new tick is accepted only once the previous one has issued its
// last channel, so no new tick is taken while the channels of the previous one
// are still being issued.
// Stall: with out_tvalid held by out_tready low, one more finished result is kept
// in a pending register and the next tick is accepted only after that drains.
// Reset: registers return to 500, the cycle restarts at the discarded start tick,
// and all memory entries read as zero sum and armed until first rewritten.
module baseline_gesture_event_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // strain_index, strain_middle, strain_ring, accel_x, accel_y, accel_z (16 bit each)
  input  logic [gev_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // event_bits [11:0], zero pad [15:12]
  output logic [gev_pkg::OUT_DATA_W-1:0]    out_tdata,
  // is_summary [0], phase [3:1]
  output logic [gev_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gev_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gev_pkg::CFG_W-1:0]         cfg_data
);

  logic [gev_pkg::CFG_W-1:0]      strain_thr_r;
  logic [gev_pkg::CFG_W-1:0]      accel_band_r;
  logic [gev_pkg::TICK_W-1:0]     tick_r;
  logic [gev_pkg::TICK_W-1:0]     tick_nxt;
  logic [gev_pkg::PHASE_W-1:0]    kind_nxt;
  logic                           run_r;
  logic [gev_pkg::CH_W-1:0]       step_r;
  logic [gev_pkg::PHASE_W-1:0]    item_kind_r;
  logic [gev_pkg::IN_DATA_W-1:0]  samples_r;
  logic [gev_pkg::EV_W-1:0]       acc_r;
  logic [gev_pkg::EV_W-1:0]       window_r;
  logic                           pend_v_r;
  logic [gev_pkg::EV_W-1:0]       pend_bits_r;
  logic [gev_pkg::PHASE_W-1:0]    pend_kind_r;
  logic                           out_tvalid_r;
  logic [gev_pkg::EV_W-1:0]       out_bits_r;
  logic [gev_pkg::PHASE_W-1:0]    out_kind_r;

  logic                           in_acc;
  logic                           fin;
  logic                           out_free;
  logic [gev_pkg::EV_W-1:0]       item_bits;
  logic [gev_pkg::EV_W-1:0]       fin_bits;

  gev_pkg::gev_req_t              req;
  gev_pkg::gev_done_t             done;

  gev_chan_pipe u_chan_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .strain_thr (strain_thr_r),
    .accel_band (accel_band_r),
    .done       (done)
  );

  // with a result on hold, wait for the tail of the previous tick to land first
  assign in_tready = !run_r && !pend_v_r && !(out_tvalid_r && done.busy);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (tick_r == '0) begin
      kind_nxt = gev_pkg::PH_START;
    end else if (tick_r < gev_pkg::TICK_REST) begin
      kind_nxt = gev_pkg::PH_SUM;
    end else if (tick_r == gev_pkg::TICK_REST) begin
      kind_nxt = gev_pkg::PH_BASE;
    end else if (tick_r < gev_pkg::TICK_REPORT) begin
      kind_nxt = gev_pkg::PH_DETECT;
    end else if (tick_r == gev_pkg::TICK_REPORT) begin
      kind_nxt = gev_pkg::PH_REPORT;
    end else begin
      kind_nxt = gev_pkg::PH_CLEAR;
    end
    tick_nxt = (tick_r >= gev_pkg::TICK_LAST) ? '0 : tick_r + 1'b1;
  end

  assign req.vld    = run_r;
  assign req.ch     = step_r;
  assign req.kind   = item_kind_r;
  assign req.sample = samples_r[step_r * gev_pkg::SAMPLE_W +: gev_pkg::SAMPLE_W];

  assign fin       = done.vld && done.last;
  assign item_bits = acc_r | done.bits;
  assign fin_bits  = (done.kind == gev_pkg::PH_REPORT) ? window_r : item_bits;
  assign out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strain_thr_r <= gev_pkg::STRAIN_THR_RST;
      accel_band_r <= gev_pkg::ACCEL_BAND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        gev_pkg::REG_STRAIN_THR: strain_thr_r <= cfg_data;
        gev_pkg::REG_ACCEL_BAND: accel_band_r <= cfg_data;
        default: begin
          strain_thr_r <= strain_thr_r;
        end
      endcase
    end
  end

  // tick sequencer: one channel step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      run_r  <= 1'b0;
      step_r <= '0;
    end else if (in_acc) begin
      tick_r <= tick_nxt;
      run_r  <= 1'b1;
      step_r <= '0;
    end else if (run_r) begin
      if (step_r == gev_pkg::LAST_CH) begin
        run_r <= 1'b0;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_kind_r <= kind_nxt;
      samples_r   <= in_tdata;
    end
  end

  // event bits gathered over the channel steps and over the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      window_r <= '0;
    end else begin
      if (done.vld) begin
        acc_r <= done.last ? '0 : item_bits;
      end
      if (fin) begin
        if (done.kind == gev_pkg::PH_DETECT) begin
          window_r <= window_r | item_bits;
        end else if (done.kind == gev_pkg::PH_CLEAR) begin
          window_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      pend_v_r     <= 1'b0;
    end else if (pend_v_r && out_free) begin
      out_tvalid_r <= 1'b1;
      pend_v_r     <= 1'b0;
    end else if (fin) begin
      if (out_free) begin
        out_tvalid_r <= 1'b1;
      end else begin
        pend_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_v_r && out_free) begin
      out_bits_r <= pend_bits_r;
      out_kind_r <= pend_kind_r;
    end else if (fin) begin
      if (out_free) begin
        out_bits_r <= fin_bits;
        out_kind_r <= done.kind;
      end else begin
        pend_bits_r <= fin_bits;
        pend_kind_r <= done.kind;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(gev_pkg::OUT_DATA_W - gev_pkg::EV_W){1'b0}}, out_bits_r};
  assign out_tuser  = {out_kind_r, (out_kind_r == gev_pkg::PH_REPORT)};

  a_no_pending_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !pend_v_r)
    else $error("tick finished while a result was already pending");

  a_pending_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> out_tvalid_r)
    else $error("pending result without an output result ahead of it");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> run_r && (step_r == '0))
    else $error("accepted tick did not start its channel walk");

  a_tick_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r <= gev_pkg::TICK_LAST)
    else $error("tick position beyond the end of the cycle");

endmodule

>>> tb/sv/baseline_gesture_event_detector_tb.sv
// self-checking testbench for the baseline gesture event detector: stream driver, monitor, predictor
module baseline_gesture_event_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_TICKS    = gev_pkg::REST_TICKS + gev_pkg::SIGN_TICKS + 2;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;
  localparam int NUM_SETTINGS   = 6;
  localparam int TICKS_PER_SET  = 80;

  typedef struct packed {
    logic [gev_pkg::EV_W-1:0]    bits;
    logic                        summary;
    logic [gev_pkg::PHASE_W-1:0] phase;
  } tick_result_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [gev_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [gev_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [gev_pkg::OUT_USER_W-1:0]   out_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [gev_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [gev_pkg::CFG_W-1:0]        cfg_data = '0;

  baseline_gesture_event_detector dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // pending ticks and expected results
  logic [gev_pkg::IN_DATA_W-1:0] tick_queue [$];
  tick_result_t                  expected_ticks [$];

  // predictor copy of the block
  logic [gev_pkg::CFG_W-1:0] thr_reg;
  logic [gev_pkg::CFG_W-1:0] band_reg;
  int unsigned               tick_pos;
  int                        base_acc [gev_pkg::NUM_CH];
  bit                        finger_flat [gev_pkg::NUM_FINGER];
  bit                        axis_armed [gev_pkg::NUM_FINGER];
  logic [gev_pkg::EV_W-1:0]  window_or;

  // generator view of the cycle
  int unsigned ticks_made;
  int          gen_center [gev_pkg::NUM_CH];
  int          gen_sum [gev_pkg::NUM_CH];
  int          gen_base [gev_pkg::NUM_CH];
  bit          noise_cycle;

  // idling control: percentages, quiet and hold_req written by the stimulus at the falling edge
  int src_idle_pct;
  int sink_idle_pct;
  bit quiet;
  int hold_req;
  int hold_ack;
  int src_gap;
  int sink_gap;

  int mismatch_count = 0;
  int ticks_checked = 0;
  int reports_seen = 0;
  int cfg_writes;
  int stall_cycles = 0;
  int idle_count = 0;

  function automatic void clear_detector();
    tick_pos = 0;
    window_or = '0;
    for (int i = 0; i < gev_pkg::NUM_CH; i++) base_acc[i] = 0;
    for (int i = 0; i < gev_pkg::NUM_FINGER; i++) begin
      finger_flat[i] = 1'b1;
      axis_armed[i] = 1'b1;
    end
  endfunction

  function automatic void predict_tick(input logic [gev_pkg::IN_DATA_W-1:0] data);
    int s [gev_pkg::NUM_CH];
    int thr;
    int band;
    int base;
    tick_result_t r;
    thr = int'(thr_reg);
    band = int'(band_reg);
    r = '0;
    for (int i = 0; i < gev_pkg::NUM_CH; i++)
      s[i] = int'($signed(data[i*gev_pkg::SAMPLE_W +: gev_pkg::SAMPLE_W]));
    if (tick_pos == 0) begin
      r.phase = gev_pkg::PH_START;
      tick_pos++;
    end else if (tick_pos < gev_pkg::REST_TICKS) begin
      for (int i = 0; i < gev_pkg::NUM_CH; i++) base_acc[i] += s[i];
      r.phase = gev_pkg::PH_SUM;
      tick_pos++;
    end else if (tick_pos == gev_pkg::REST_TICKS) begin
      // sum of REST_TICKS-1 samples over REST_TICKS, truncating toward zero
      for (int i = 0; i < gev_pkg::NUM_CH; i++)
        base_acc[i] = base_acc[i] / gev_pkg::REST_TICKS;
      r.phase = gev_pkg::PH_BASE;
      tick_pos++;
    end else if (tick_pos < gev_pkg::REST_TICKS + gev_pkg::SIGN_TICKS) begin
      for (int i = 0; i < gev_pkg::NUM_FINGER; i++) begin
        if (s[i] <= base_acc[i] + thr) begin
          if (!finger_flat[i]) begin
            finger_flat[i] = 1'b1;
            r.bits[11 - 2*i] = 1'b1;
          end
        end else if (finger_flat[i]) begin
          finger_flat[i] = 1'b0;
          r.bits[10 - 2*i] = 1'b1;
        end
      end
      for (int i = 0; i < gev_pkg::NUM_FINGER; i++) begin
        base = base_acc[gev_pkg::NUM_FINGER + i];
        if (s[gev_pkg::NUM_FINGER + i] <= base + band &&
            s[gev_pkg::NUM_FINGER + i] >= base - band) begin
          axis_armed[i] = 1'b1;
        end else if (axis_armed[i]) begin
          axis_armed[i] = 1'b0;
          if (s[gev_pkg::NUM_FINGER + i] < base) r.bits[5 - 2*i] = 1'b1;
          else if (s[gev_pkg::NUM_FINGER + i] > base) r.bits[4 - 2*i] = 1'b1;
        end
      end
      window_or |= r.bits;
      r.phase = gev_pkg::PH_DETECT;
      tick_pos++;
    end else if (tick_pos == gev_pkg::REST_TICKS + gev_pkg::SIGN_TICKS) begin
      r.bits = window_or;
      r.summary = 1'b1;
      r.phase = gev_pkg::PH_REPORT;
      tick_pos++;
    end else begin
      clear_detector();
      r.phase = gev_pkg::PH_CLEAR;
    end
    expected_ticks.push_back(r);
  endfunction

  function automatic int rand_sample();
    logic signed [gev_pkg::SAMPLE_W-1:0] r16;
    r16 = gev_pkg::SAMPLE_W'($urandom());
    return int'(r16);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [gev_pkg::IN_DATA_W-1:0] pack_tick(input int v [gev_pkg::NUM_CH]);
    logic [gev_pkg::IN_DATA_W-1:0] d;
    for (int i = 0; i < gev_pkg::NUM_CH; i++)
      d[i*gev_pkg::SAMPLE_W +: gev_pkg::SAMPLE_W] = v[i][gev_pkg::SAMPLE_W-1:0];
    return d;
  endfunction

  // samples shaped by where the tick lands in the cycle: quiet rest, then edges near the limits
  function automatic logic [gev_pkg::IN_DATA_W-1:0] make_tick();
    int v [gev_pkg::NUM_CH];
    int pos;
    int off;
    int delta;
    bit noisy;
    pos = int'(ticks_made % CYCLE_TICKS);
    if (pos == 0) begin
      noise_cycle = ($urandom_range(9) == 0);
      for (int i = 0; i < gev_pkg::NUM_CH; i++) begin
        gen_sum[i] = 0;
        if ($urandom_range(3) == 0) gen_center[i] = rand_sample();
        else gen_center[i] = int'($urandom_range(6000)) - 3000;
      end
    end
    noisy = noise_cycle || ($urandom_range(19) == 0);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) begin
      delta = int'($urandom_range(4)) - 2;
      off = (i < gev_pkg::NUM_FINGER) ? int'(thr_reg) : int'(band_reg);
      if (noisy || pos == 0 || pos >= gev_pkg::REST_TICKS + gev_pkg::SIGN_TICKS ||
          pos == gev_pkg::REST_TICKS) begin
        v[i] = rand_sample();
      end else if (pos < gev_pkg::REST_TICKS) begin
        v[i] = clamp16(gen_center[i] + int'($urandom_range(80)) - 40);
      end else begin
        case ($urandom_range(3))
          0: v[i] = clamp16(gen_base[i] + off + delta);
          1: v[i] = clamp16(gen_base[i] - off + delta);
          2: v[i] = clamp16(gen_base[i] + delta);
          default: v[i] = rand_sample();
        endcase
      end
      if (pos >= 1 && pos < gev_pkg::REST_TICKS) gen_sum[i] += v[i];
      if (pos == gev_pkg::REST_TICKS) gen_base[i] = gen_sum[i] / gev_pkg::REST_TICKS;
    end
    ticks_made++;
    return pack_tick(v);
  endfunction

  function automatic void push_tick(input int v [gev_pkg::NUM_CH]);
    tick_queue.push_back(pack_tick(v));
    ticks_made++;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      src_gap <= 0;
      clear_detector();
    end else begin
      if (in_tvalid && in_tready) predict_tick(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!quiet && int'($urandom_range(99)) < src_idle_pct) begin
          src_gap <= $urandom_range(16);
          in_tvalid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= tick_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap <= 0;
      hold_ack <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      sink_gap <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet && int'($urandom_range(99)) < sink_idle_pct) begin
      sink_gap <= $urandom_range(16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (rst_n && in_tvalid && !in_tready) stall_cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none actual %0h/%0h",
                   $time, out_tdata, out_tuser);
      end else begin
        want = expected_ticks.pop_front();
        check_field("event_bits", 32'(want.bits), 32'(out_tdata[gev_pkg::EV_W-1:0]));
        check_field("pad", 0, 32'(out_tdata[gev_pkg::OUT_DATA_W-1:gev_pkg::EV_W]));
        check_field("is_summary", 32'(want.summary), 32'(out_tuser[0]));
        check_field("phase", 32'(want.phase), 32'(out_tuser[gev_pkg::PHASE_W:1]));
        ticks_checked++;
        if (want.summary) reports_seen++;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", idle_count, $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_count <= idle_count + 1;
  end

  task automatic write_reg(input logic [gev_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [gev_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_addr <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      gev_pkg::REG_STRAIN_THR: thr_reg = val;
      gev_pkg::REG_ACCEL_BAND: band_reg = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic drain();
    do @(negedge clk); while (tick_queue.size() != 0 || in_tvalid || expected_ticks.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int v [gev_pkg::NUM_CH];
    logic [gev_pkg::CFG_W-1:0] thr_pick;
    logic [gev_pkg::CFG_W-1:0] band_pick;
    thr_reg = gev_pkg::STRAIN_THR_RST;
    band_reg = gev_pkg::ACCEL_BAND_RST;
    ticks_made = 0;
    src_idle_pct = 20;
    sink_idle_pct = 20;
    quiet = 1'b0;
    hold_req = 0;
    cfg_writes = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes and bit patterns land in the discarded and summing ticks
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = 0;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = 32767;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = -32768;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = 16'sh5555;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = -21846;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = (i % 2) ? 32767 : -32768;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = -1;
    push_tick(v);
    for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = 1;
    push_tick(v);
    for (int n = 0; n < 16; n++) begin
      for (int i = 0; i < gev_pkg::NUM_CH; i++) v[i] = int'($urandom_range(200)) - 100;
      push_tick(v);
    end
    drain();

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: begin thr_pick = '0; band_pick = '0; end
        1: begin thr_pick = '1; band_pick = '1; end
        2: begin
          thr_pick = gev_pkg::CFG_W'($urandom_range(2000, 1));
          band_pick = gev_pkg::CFG_W'($urandom_range(2000, 1));
        end
        3: begin thr_pick = '0; band_pick = '1; end
        4: begin
          thr_pick = gev_pkg::CFG_W'($urandom());
          band_pick = gev_pkg::CFG_W'($urandom());
        end
        default: begin
          thr_pick = gev_pkg::STRAIN_THR_RST;
          band_pick = gev_pkg::CFG_W'($urandom_range(50));
        end
      endcase
      write_reg(gev_pkg::REG_STRAIN_THR, thr_pick);
      write_reg(gev_pkg::REG_ACCEL_BAND, band_pick);
      @(negedge clk);
      case ($urandom_range(2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 10;
        default: src_idle_pct = 35;
      endcase
      sink_idle_pct = (ph == 3) ? 0 : int'($urandom_range(40));
      quiet = (ph == NUM_SETTINGS - 1);
      for (int n = 0; n < TICKS_PER_SET; n++) tick_queue.push_back(make_tick());
      // receiver holds off while the sender keeps offering, so the block backs up
      if (ph == 1) hold_req++;
      drain();
    end

    $display("checked %0d ticks, %0d window reports, %0d register writes", ticks_checked,
             reports_seen, cfg_writes);
    $display("%0d cycles of input backpressure over %0d threshold/band settings", stall_cycles,
             NUM_SETTINGS + 1);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/gev_pkg.sv
rtl/gev_ram.sv
rtl/gev_chan_pipe.sv
rtl/baseline_gesture_event_detector.sv
tb/sv/baseline_gesture_event_detector_tb.sv
